>>> hw/rtl/fsp_pkg.sv
// shared constants, codes and fixed-point gains for the flywheel speed controller
// no dependencies; used by fsp_sdiv, flywheel_speed_pid_controller and the testbench
package fsp_pkg;

  // field widths
  localparam int ACT_W      = 3;
  localparam int CAP_W      = 32;
  localparam int TGT_W      = 15;
  localparam int RPM_W      = 16;
  localparam int DUTY_W     = 7;
  localparam int TOL_W      = 12;
  localparam int TMO_W      = 16;
  localparam int SCALE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // fixed-point layout
  localparam int GAIN_FRAC_BITS = 32;
  localparam int PERIOD_WIDTH   = 32;
  localparam int INT_FRAC       = 24;
  localparam int INT_W          = 32;
  localparam int ERR_W          = 18;
  localparam int MUL_W          = ERR_W + 1;
  localparam int MCNT_W         = $clog2(MUL_W);
  localparam int SUM_W          = GAIN_FRAC_BITS + 24;
  localparam int DIV_W          = SCALE_W;
  localparam int DCNT_W         = $clog2(DIV_W);

  // gains, rounded to nearest with GAIN_FRAC_BITS fraction bits
  localparam logic [63:0] KP_START_Q = ((64'd5 << GAIN_FRAC_BITS) + 64'd1) / 64'd2;
  localparam logic [63:0] KP_BELOW_Q = ((64'd145 << GAIN_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] KP_ABOVE_Q =
    ((64'd1 << GAIN_FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] KD_ABOVE_Q = ((64'd15 << GAIN_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] KI_BELOW_Q = ((64'd95 << GAIN_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] KI_ABOVE_Q = ((64'd55 << GAIN_FRAC_BITS) + 64'd50000) / 64'd100000;

  // limits
  localparam logic [63:0] INT_MAX_Q = 64'd100 << INT_FRAC;
  localparam int DUTY_MAX = 50;
  localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

  // input actions
  typedef enum logic [ACT_W-1:0] {
    ACT_EDGE    = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_START   = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_STOPPED = 3'd4
  } action_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RPM_SCALE  = 3'd0,
    REG_READY_TOL  = 3'd1,
    REG_READY_TMO  = 3'd2,
    REG_IDLE_SPEED = 3'd3
  } cfg_reg_t;

endpackage

>>> hw/rtl/flywheel_speed_pid_controller.sv
// flywheel speed controller: period capture, rpm by serial division, ready check, PID
// depends on fsp_pkg and fsp_sdiv
//
//  channel | direction | handshake             | payload
//  in_     | in        | in_valid / in_ready   | action, capture_time, target_rpm
//  out_    | out       | out_valid / out_ready | duty_valid, duty, ready_res,
//          |           |                       | ready_by_timeout, speed_rpm
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// edge, start, stop and stopped items are taken and then handed off; a control tick is
// taken, runs the bit-serial divider, is evaluated, then runs each product on the shared
// bit-serial multiplier (two products below the target, four at or above it), with the
// integral update after the first, then sums and hands off the result.
// one item is in work at a time; the next is accepted while a result waits at out_.
// reset is synchronous, active low; it loads the register defaults and clears the controller state.
// a stalled output holds the next finished result in the result stage until taken.
module flywheel_speed_pid_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fsp_pkg::ACT_W-1:0]           in_action,
  input  logic [fsp_pkg::CAP_W-1:0]           in_capture_time,
  input  logic [fsp_pkg::TGT_W-1:0]           in_target_rpm,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_duty_valid,
  output logic signed [fsp_pkg::DUTY_W-1:0]   out_duty,
  output logic                                out_ready_res,
  output logic                                out_ready_by_timeout,
  output logic [fsp_pkg::RPM_W-1:0]           out_speed_rpm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fsp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIV    = 10'b0000000010,
    S_EVAL   = 10'b0000000100,
    S_MUL_I  = 10'b0000001000,
    S_INT    = 10'b0000010000,
    S_MUL_P  = 10'b0000100000,
    S_MUL_P2 = 10'b0001000000,
    S_MUL_D  = 10'b0010000000,
    S_SUM    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  localparam logic signed [SUM_W-1:0] INT_ADJ  = SUM_W'((64'd1 << (GAIN_FRAC_BITS - INT_FRAC)) - 64'd1);
  localparam logic signed [SUM_W-1:0] DUTY_ADJ = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [SUM_W-1:0] INT_MAX  = SUM_W'(INT_MAX_Q);
  localparam logic signed [SUM_W-1:0] DMAX     = SUM_W'(DUTY_MAX);
  localparam logic signed [SUM_W-1:0] ZERO_S   = '0;

  state_t state_r, state_nxt;

  // configuration registers
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [TOL_W-1:0]   tol_r, tol_nxt;
  logic [TMO_W-1:0]   tmo_r, tmo_nxt;
  logic [TGT_W-1:0]   idle_r, idle_nxt;

  // controller state
  logic [PERIOD_WIDTH-1:0] period_r, period_nxt;
  logic [PERIOD_WIDTH-1:0] last_r, last_nxt;
  logic [TGT_W-1:0]        target_r, target_nxt;
  logic                    armed_r, armed_nxt;
  logic [TMO_W-1:0]        ticks_r, ticks_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;

  // per-tick work registers
  logic [RPM_W-1:0]        rpm_r, rpm_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic                    above_r, above_nxt;
  logic                    p_two_r, p_two_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [SUM_W-1:0] mcand_r, mcand_nxt;
  logic [MUL_W-1:0]        mplier_r, mplier_nxt;
  logic [MCNT_W-1:0]       mcnt_r, mcnt_nxt;

  // result stage and output register
  logic                     res_dv_r, res_dv_nxt;
  logic signed [DUTY_W-1:0] res_duty_r, res_duty_nxt;
  logic                     res_rdy_r, res_rdy_nxt;
  logic                     res_tmo_r, res_tmo_nxt;
  logic [RPM_W-1:0]         res_spd_r, res_spd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_dv_r, out_dv_nxt;
  logic signed [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  logic                     out_rdy_r, out_rdy_nxt;
  logic                     out_tmo_r, out_tmo_nxt;
  logic [RPM_W-1:0]         out_spd_r, out_spd_nxt;

  // intermediate values
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  logic                     mul_last;
  logic signed [SUM_W-1:0]  addend;
  logic signed [SUM_W-1:0]  acc_step;
  logic signed [ERR_W-1:0]  err_w;
  logic signed [ERR_W-1:0]  diff_w;
  logic signed [ERR_W-1:0]  tol_s;
  logic [TMO_W-1:0]         tinc;
  logic signed [ERR_W+2:0]  five_e;
  logic signed [SUM_W-1:0]  inc_w;
  logic signed [SUM_W-1:0]  isum;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [SUM_W-1:0]  qd_w;

  fsp_sdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scale_r),
    .divisor  (DIV_W'(period_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared bit-serial multiplier step: multiplier lsb first, sign bit weighs negative
  assign mul_last = (mcnt_r == MCNT_W'(MUL_W - 1));
  assign addend   = mplier_r[0] ? (mul_last ? -mcand_r : mcand_r) : '0;
  assign acc_step = acc_r + addend;

  always_comb begin
    state_nxt    = state_r;
    scale_nxt    = scale_r;
    tol_nxt      = tol_r;
    tmo_nxt      = tmo_r;
    idle_nxt     = idle_r;
    period_nxt   = period_r;
    last_nxt     = last_r;
    target_nxt   = target_r;
    armed_nxt    = armed_r;
    ticks_nxt    = ticks_r;
    integ_nxt    = integ_r;
    prev_err_nxt = prev_err_r;
    rpm_nxt      = rpm_r;
    err_nxt      = err_r;
    above_nxt    = above_r;
    p_two_nxt    = p_two_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    mplier_nxt   = mplier_r;
    mcnt_nxt     = mcnt_r;
    res_dv_nxt   = res_dv_r;
    res_duty_nxt = res_duty_r;
    res_rdy_nxt  = res_rdy_r;
    res_tmo_nxt  = res_tmo_r;
    res_spd_nxt  = res_spd_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_dv_nxt   = out_dv_r;
    out_duty_nxt = out_duty_r;
    out_rdy_nxt  = out_rdy_r;
    out_tmo_nxt  = out_tmo_r;
    out_spd_nxt  = out_spd_r;
    div_start    = 1'b0;
    err_w  = $signed(ERR_W'(target_r)) - $signed(ERR_W'(rpm_r));
    diff_w = -err_w;
    tol_s  = $signed(ERR_W'(tol_r));
    tinc   = (ticks_r == {TMO_W{1'b1}}) ? ticks_r : ticks_r + 1'b1;
    five_e = ((ERR_W+3)'(err_r) <<< 2) + (ERR_W+3)'(err_r);
    inc_w  = (acc_r + ((acc_r < 0) ? INT_ADJ : ZERO_S)) >>> (GAIN_FRAC_BITS - INT_FRAC);
    isum   = SUM_W'(integ_r) + inc_w;
    sum_w  = acc_r + (SUM_W'(integ_r) <<< (GAIN_FRAC_BITS - INT_FRAC));
    qd_w   = (sum_w + ((sum_w < 0) ? DUTY_ADJ : ZERO_S)) >>> GAIN_FRAC_BITS;

    // configuration writes
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_RPM_SCALE:  scale_nxt = cfg_data[SCALE_W-1:0];
        REG_READY_TOL:  tol_nxt   = cfg_data[TOL_W-1:0];
        REG_READY_TMO:  tmo_nxt   = cfg_data[TMO_W-1:0];
        REG_IDLE_SPEED: idle_nxt  = cfg_data[TGT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // take an item; all but a tick finish here
      S_IDLE: begin
        if (in_valid) begin
          res_dv_nxt   = 1'b0;
          res_duty_nxt = '0;
          res_rdy_nxt  = 1'b0;
          res_tmo_nxt  = 1'b0;
          res_spd_nxt  = '0;
          state_nxt    = S_OUT;
          case (action_t'(in_action))
            ACT_EDGE: begin
              period_nxt = in_capture_time[PERIOD_WIDTH-1:0] - last_r;
              last_nxt   = in_capture_time[PERIOD_WIDTH-1:0];
            end
            ACT_TICK: begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            ACT_START: begin
              armed_nxt  = 1'b1;
              target_nxt = in_target_rpm;
            end
            ACT_STOP: begin
              armed_nxt  = 1'b0;
              target_nxt = idle_r;
            end
            ACT_STOPPED: period_nxt = '0;
            default: ;
          endcase
        end
      end
      // wait for rpm_scale / period
      S_DIV: begin
        if (div_done) begin
          if (period_r == '0) begin
            rpm_nxt = '0;
          end else if (div_q > DIV_W'(RPM_MAX)) begin
            rpm_nxt = RPM_MAX;
          end else begin
            rpm_nxt = div_q[RPM_W-1:0];
          end
          state_nxt = S_EVAL;
        end
      end
      // error, ready check, start the integral product
      S_EVAL: begin
        err_nxt     = err_w;
        above_nxt   = (err_w <= 0);
        res_spd_nxt = rpm_r;
        if (armed_r) begin
          if (diff_w <= tol_s && diff_w >= -tol_s) begin
            res_rdy_nxt = 1'b1;
            armed_nxt   = 1'b0;
            ticks_nxt   = '0;
          end else if (tinc > tmo_r) begin
            res_rdy_nxt = 1'b1;
            res_tmo_nxt = 1'b1;
            armed_nxt   = 1'b0;
            ticks_nxt   = '0;
          end else begin
            ticks_nxt = tinc;
          end
        end
        acc_nxt    = '0;
        mcand_nxt  = (err_w <= 0) ? SUM_W'(KI_ABOVE_Q) : SUM_W'(KI_BELOW_Q);
        mplier_nxt = MUL_W'(err_w);
        mcnt_nxt   = '0;
        state_nxt  = S_MUL_I;
      end
      // integral update, then start the proportional product
      S_INT: begin
        if (isum > INT_MAX) begin
          integ_nxt = INT_W'(INT_MAX);
        end else if (isum < -INT_MAX) begin
          integ_nxt = INT_W'(-INT_MAX);
        end else begin
          integ_nxt = INT_W'(isum);
        end
        acc_nxt    = '0;
        mplier_nxt = MUL_W'(err_r);
        mcnt_nxt   = '0;
        p_two_nxt  = 1'b0;
        if (five_e > $signed((ERR_W+3)'(target_r))) begin
          mcand_nxt = SUM_W'(KP_START_Q);
        end else if (above_r) begin
          mcand_nxt = SUM_W'(KP_ABOVE_Q);
          p_two_nxt = 1'b1;
        end else begin
          mcand_nxt = SUM_W'(KP_BELOW_Q);
        end
        state_nxt = S_MUL_P;
      end
      // serial products
      S_MUL_I, S_MUL_P, S_MUL_P2, S_MUL_D: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        mcnt_nxt   = mcnt_r + 1'b1;
        if (mul_last) begin
          mcnt_nxt = '0;
          if (state_r == S_MUL_I) begin
            state_nxt = S_INT;
          end else if (state_r == S_MUL_P && p_two_r) begin
            // second factor of the squared-error term
            acc_nxt    = '0;
            mcand_nxt  = acc_step;
            mplier_nxt = -MUL_W'(err_r);
            state_nxt  = S_MUL_P2;
          end else if (state_r != S_MUL_D && above_r) begin
            // derivative product accumulates on top of the p term
            mcand_nxt  = SUM_W'(KD_ABOVE_Q);
            mplier_nxt = MUL_W'(err_r) - MUL_W'(prev_err_r);
            state_nxt  = S_MUL_D;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      // add the integral, truncate and clamp the duty
      S_SUM: begin
        prev_err_nxt = err_r;
        res_dv_nxt   = (target_r != '0);
        if (target_r == '0) begin
          res_duty_nxt = '0;
        end else if (qd_w > DMAX) begin
          res_duty_nxt = DUTY_W'(DMAX);
        end else if (qd_w < -DMAX) begin
          res_duty_nxt = DUTY_W'(-DMAX);
        end else begin
          res_duty_nxt = DUTY_W'(qd_w);
        end
        state_nxt = S_OUT;
      end
      // move the result into the output register when it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dv_nxt    = res_dv_r;
          out_duty_nxt  = res_duty_r;
          out_rdy_nxt   = res_rdy_r;
          out_tmo_nxt   = res_tmo_r;
          out_spd_nxt   = res_spd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= SCALE_W'(240000000);
      tol_r       <= TOL_W'(200);
      tmo_r       <= TMO_W'(100);
      idle_r      <= '0;
      period_r    <= '0;
      last_r      <= '0;
      target_r    <= '0;
      armed_r     <= 1'b0;
      ticks_r     <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      tol_r       <= tol_nxt;
      tmo_r       <= tmo_nxt;
      idle_r      <= idle_nxt;
      period_r    <= period_nxt;
      last_r      <= last_nxt;
      target_r    <= target_nxt;
      armed_r     <= armed_nxt;
      ticks_r     <= ticks_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rpm_r      <= rpm_nxt;
    err_r      <= err_nxt;
    above_r    <= above_nxt;
    p_two_r    <= p_two_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    mcnt_r     <= mcnt_nxt;
    res_dv_r   <= res_dv_nxt;
    res_duty_r <= res_duty_nxt;
    res_rdy_r  <= res_rdy_nxt;
    res_tmo_r  <= res_tmo_nxt;
    res_spd_r  <= res_spd_nxt;
    out_dv_r   <= out_dv_nxt;
    out_duty_r <= out_duty_nxt;
    out_rdy_r  <= out_rdy_nxt;
    out_tmo_r  <= out_tmo_nxt;
    out_spd_r  <= out_spd_nxt;
  end

  assign in_ready             = (state_r == S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_duty_valid       = out_dv_r;
  assign out_duty             = out_duty_r;
  assign out_ready_res        = out_rdy_r;
  assign out_ready_by_timeout = out_tmo_r;
  assign out_speed_rpm        = out_spd_r;

`ifndef SYNTH
  // duty stays within the clamp
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_duty_valid) |-> (out_duty <= 7'sd50 && out_duty >= -7'sd50))
    else $error("duty out of range");

  // a timeout completion is always a ready pulse
  a_tmo_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready_by_timeout) |-> out_ready_res)
    else $error("timeout without ready");

  // an accepted item makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted item did not occupy the block");

  // integral never leaves its clamp
  a_integ_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= INT_W'(INT_MAX) && integ_r >= INT_W'(-INT_MAX)))
    else $error("integral out of range");
`endif

endmodule

>>> hw/rtl/fsp_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on fsp_pkg
module fsp_sdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fsp_pkg::DIV_W-1:0] dividend,
  input  logic [fsp_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [fsp_pkg::DIV_W-1:0] quotient
);
  import fsp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    trial    = shifted - {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = trial[DIV_W] ? shifted : trial;
      quo_nxt = {quo_r[DIV_W-2:0], ~trial[DIV_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> test/tb_flywheel_speed_pid_controller.sv
// self-checking testbench for flywheel_speed_pid_controller: a scoreboard class
// predicts every result item from the accepted input items; depends on fsp_pkg
`timescale 1ns / 1ps

module tb_flywheel_speed_pid_controller;
  import fsp_pkg::*;

  // gains in signed Q.32, rounded to nearest
  localparam longint KP_START_G = ((longint'(5) << 32) + 1) / 2;
  localparam longint KP_BELOW_G = ((longint'(145) << 32) + 50000) / 100000;
  localparam longint KP_ABOVE_G = ((longint'(1) << 32) + 5000000) / 10000000;
  localparam longint KD_ABOVE_G = ((longint'(15) << 32) + 500000) / 1000000;
  localparam longint KI_BELOW_G = ((longint'(95) << 32) + 500000) / 1000000;
  localparam longint KI_ABOVE_G = ((longint'(55) << 32) + 50000) / 100000;
  localparam longint INTEG_LIM  = longint'(100) << 24;
  localparam longint Q24_SHIFT  = longint'(1) << 8;
  localparam longint ONE_G      = longint'(1) << 32;
  localparam logic [ACT_W-1:0]     ACT_RESERVED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd5;

  typedef struct packed {
    logic              duty_valid;
    logic signed [6:0] duty;
    logic              ready_res;
    logic              by_timeout;
    logic [15:0]       speed;
  } ctrl_result_t;

  // predicts the controller and holds the results still owed by it
  class speed_scoreboard;
    logic [31:0] scale;
    logic [11:0] tol;
    logic [15:0] tmo;
    logic [14:0] idle_rpm;
    logic [31:0] period, last_cap;
    logic [14:0] tgt_speed;
    bit          armed;
    logic [15:0] ticks;
    longint      integ, prev_err;
    ctrl_result_t owed[$];
    int errors, n_ticks, n_ready, n_timeout, n_duty, n_checked;

    function void clear();
      scale = 32'd240000000; tol = 12'd200; tmo = 16'd100; idle_rpm = '0;
      period = '0; last_cap = '0; tgt_speed = '0; armed = 0; ticks = '0;
      integ = 0; prev_err = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_RPM_SCALE:  scale = data;
        REG_READY_TOL:  tol = data[11:0];
        REG_READY_TMO:  tmo = data[15:0];
        REG_IDLE_SPEED: idle_rpm = data[14:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // pid law on one tick, returns the clamped duty
    function longint pid_step(logic [15:0] rpm);
      longint e, ki, p, d, sum;
      bit abv;
      e = longint'(tgt_speed) - longint'(rpm);
      abv = (e <= 0);
      ki = abv ? KI_ABOVE_G : KI_BELOW_G;
      integ = clamp(integ + (ki * e) / Q24_SHIFT, -INTEG_LIM, INTEG_LIM);
      if (5 * e > longint'(tgt_speed)) p = KP_START_G * e;
      else if (abv) p = KP_ABOVE_G * (-e) * e;
      else p = KP_BELOW_G * e;
      d = abv ? KD_ABOVE_G * (e - prev_err) : 0;
      prev_err = e;
      sum = p + d + integ * Q24_SHIFT;
      return clamp(sum / ONE_G, -50, 50);
    endfunction

    function void note_input(logic [ACT_W-1:0] act, logic [31:0] cap, logic [14:0] tgt);
      ctrl_result_t r;
      logic [31:0] q;
      logic [15:0] rpm;
      longint diff, dv;
      r = '0;
      case (act)
        ACT_EDGE: begin
          period = cap - last_cap;
          last_cap = cap;
        end
        ACT_TICK: begin
          n_ticks++;
          q = (period == 0) ? 32'd0 : scale / period;
          rpm = (q > 32'd65535) ? 16'hFFFF : q[15:0];
          r.speed = rpm;
          if (armed) begin
            diff = longint'(rpm) - longint'(tgt_speed);
            if (diff <= longint'(tol) && diff >= -longint'(tol)) begin
              r.ready_res = 1; armed = 0; ticks = '0;
            end else begin
              if (ticks != 16'hFFFF) ticks++;
              if (ticks > tmo) begin
                r.ready_res = 1; r.by_timeout = 1; armed = 0; ticks = '0;
              end
            end
          end
          dv = pid_step(rpm);
          if (tgt_speed != 0) begin
            r.duty_valid = 1;
            r.duty = dv[6:0];
          end
          n_ready += r.ready_res;
          n_timeout += r.by_timeout;
          n_duty += r.duty_valid;
        end
        ACT_START: begin
          armed = 1; tgt_speed = tgt;
        end
        ACT_STOP: begin
          armed = 0; tgt_speed = idle_rpm;
        end
        ACT_STOPPED: period = '0;
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(ctrl_result_t got);
      ctrl_result_t want;
      if (owed.size() == 0) begin
        report("unexpected result item", 1, 0);
        return;
      end
      want = owed.pop_front();
      n_checked++;
      if (got.duty_valid !== want.duty_valid)
        report("duty_valid", got.duty_valid, want.duty_valid);
      if (got.duty !== want.duty) report("duty", got.duty, want.duty);
      if (got.ready_res !== want.ready_res)
        report("ready_res", got.ready_res, want.ready_res);
      if (got.by_timeout !== want.by_timeout)
        report("ready_by_timeout", got.by_timeout, want.by_timeout);
      if (got.speed !== want.speed) report("speed_rpm", got.speed, want.speed);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [ACT_W-1:0] in_action = '0;
  logic [CAP_W-1:0] in_capture_time = '0;
  logic [TGT_W-1:0] in_target_rpm = '0;
  logic out_valid, out_ready = 0;
  logic out_duty_valid, out_ready_res, out_ready_by_timeout;
  logic signed [DUTY_W-1:0] out_duty;
  logic [RPM_W-1:0] out_speed_rpm;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  speed_scoreboard sb;
  int in_idle_pct = 0, out_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  logic [31:0] stim_cap = '0;
  int n_items = 0;

  flywheel_speed_pid_controller u_top (.*);

  // 4 ns clock
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_duty_valid, out_duty, out_ready_res, out_ready_by_timeout,
                        out_speed_rpm});
  end

  // send one input item, returns at the edge where it is accepted
  task send(input logic [ACT_W-1:0] act, input logic [31:0] cap, input logic [14:0] tgt);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_capture_time <= cap;
    in_target_rpm <= tgt;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, cap, tgt);
    n_items++;
  endtask

  // encoder edge one period after the previous one
  task edge_after(input logic [31:0] per);
    stim_cap = stim_cap + per;
    send(ACT_EDGE, stim_cap, $urandom_range(20000));
  endtask

  // write one register; the caller drops cfg_valid after the last write
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // wait until every owed result has come back and the block has settled
  task drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // random items: mostly start-edge-tick bursts near the target, some noise
  task run_random(input int count);
    int stop_at, k;
    logic [14:0] t;
    longint nominal, per;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send($urandom_range(7), $urandom, $urandom_range(20000));
      end else begin
        t = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(20000, 300));
        send(ACT_START, $urandom, t);
        k = $urandom_range(20, 3);
        repeat (k) begin
          nominal = (t == 0) ? longint'($urandom) : longint'(sb.scale) / longint'(t);
          if (nominal == 0) nominal = 1;
          per = nominal + longint'($urandom_range(32'(nominal / 4))) - nominal / 8;
          if ($urandom_range(9) == 0) per = $urandom;
          edge_after(per[31:0]);
          send(ACT_TICK, $urandom, $urandom_range(20000));
          case ($urandom_range(29))
            0: send(ACT_STOP, $urandom, $urandom_range(20000));
            1: send(ACT_STOPPED, $urandom, $urandom_range(20000));
            default: ;
          endcase
        end
      end
    end
  endtask

  // watchdog
  initial begin
    #40000000;
    $display("[flywheel_speed_pid_controller] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: wrap of the period, saturation, zero period, reserved actions
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_START, 32'hFFFF_FFFF, 15'd20000);
    send(ACT_EDGE, 32'hFFFF_FFFF, 15'h7FFF);
    send(ACT_EDGE, 32'h0000_0001, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_EDGE, 32'h0000_0000, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_STOPPED, 32'd0, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_START, 32'd0, 15'd12000);
    send(ACT_EDGE, 32'd20000, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_EDGE, 32'd40000, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(ACT_STOP, 32'd0, 15'd0);
    send(ACT_TICK, 32'd0, 15'd0);
    send(3'd5, 32'hA5A5_5A5A, 15'd20000);
    send(3'd6, 32'h5A5A_A5A5, 15'd16384);
    send(ACT_RESERVED, 32'hFFFF_FFFF, 15'd20000);
    send(ACT_TICK, 32'd0, 15'd0);
    stim_cap = 32'd40000;

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(REG_RPM_SCALE, 32'd1);
          write_reg(REG_READY_TOL, 32'd0);
          write_reg(REG_READY_TMO, 32'd0);
          write_reg(REG_IDLE_SPEED, 32'd20000);
        end
        2: begin
          write_reg(REG_RPM_SCALE, 32'hFFFF_FFFF);
          write_reg(REG_READY_TOL, 32'd4095);
          write_reg(REG_READY_TMO, 32'd65535);
          write_reg(REG_IDLE_SPEED, 32'd0);
        end
        3: begin
          write_reg(REG_RPM_SCALE, 32'd240000000);
          write_reg(REG_READY_TOL, 32'd50);
          write_reg(REG_READY_TMO, 32'd20);
          write_reg(REG_IDLE_SPEED, 32'd1500);
        end
        4: begin
          write_reg(REG_RPM_SCALE, $urandom_range(400000000, 100000000));
          write_reg(REG_READY_TOL, $urandom);
          write_reg(REG_READY_TMO, $urandom_range(200));
          write_reg(REG_IDLE_SPEED, $urandom_range(20000));
          hold_req = 1;
        end
        5: begin
          write_reg(REG_UNUSED, $urandom);
          write_reg(REG_RPM_SCALE, 32'd0);
          write_reg(REG_READY_TMO, $urandom);
          write_reg(REG_IDLE_SPEED, $urandom);
        end
        default: ;
      endcase
      cfg_valid <= 0;
      // idling pattern: none, sender, receiver, both
      case (ph % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 57; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 57; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      run_random(205);
    end

    drain();
    $display("covered %0d items, %0d results checked: %0d ticks, %0d duty updates,",
             n_items, sb.n_checked, sb.n_ticks, sb.n_duty);
    $display("%0d ready pulses (%0d by timeout) over six register settings",
             sb.n_ready, sb.n_timeout);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[flywheel_speed_pid_controller] OK");
    end else begin
      $display("[flywheel_speed_pid_controller] ERROR");
    end
    $finish;
  end

endmodule
